/* design/line_position_lost_line_tracker_macros.svh */
// Assertion macros for the line position tracker.
// Included by the top level; no other dependencies.
`ifndef LINE_POSITION_LOST_LINE_TRACKER_MACROS_SVH
`define LINE_POSITION_LOST_LINE_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define LPLT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lplt: same-cycle check failed");
`define LPLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lplt: next-cycle check failed");
`else
`define LPLT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LPLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/lplt_pkg.sv */
// Shared types, constants and the sensor weight function of the line tracker.
// No dependencies.
package lplt_pkg;

	typedef logic [7:0]         bits_t;
	typedef logic [7:0]         count_t;
	typedef logic signed [11:0] pos_t;
	typedef logic [1:0]         status_t;

	localparam status_t ST_TRACK = 2'd0;
	localparam status_t ST_COAST = 2'd1;
	localparam status_t ST_EDGE  = 2'd2;
	localparam status_t ST_NODE  = 2'd3;

	localparam bits_t  RESET_PATTERN   = 8'h18;
	localparam bits_t  EDGE_LEFT_ONLY  = 8'h01;
	localparam bits_t  EDGE_RIGHT_ONLY = 8'h80;
	localparam count_t RESET_THRESHOLD = 8'd10;
	localparam count_t COUNT_MAX       = 8'd255;

	// divider: 12 quotient bits, two per cycle
	localparam int DIV_BITS_PER_STEP = 2;
	localparam int DIV_STEPS         = 12 / DIV_BITS_PER_STEP;
	localparam int CNT_W             = $clog2(DIV_STEPS);

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} lplt_cmd_t;

	// weights -4,-3,-2,-1,+1,+2,+3,+4 from left to right
	function automatic logic signed [3:0] sensor_weight(input logic [2:0] k);
		logic signed [3:0] w;
		unique case (k)
			3'd0: w = -4'sd4;
			3'd1: w = -4'sd3;
			3'd2: w = -4'sd2;
			3'd3: w = -4'sd1;
			3'd4: w = 4'sd1;
			3'd5: w = 4'sd2;
			3'd6: w = 4'sd3;
			3'd7: w = 4'sd4;
			default: w = 4'sd0;
		endcase
		return w;
	endfunction

endpackage

/* design/lplt_if.sv */
// Valid/ready channel interfaces for sensor words and result words.
// Depends on lplt_pkg.
interface lplt_in_if;
	logic               valid;
	logic               ready;
	lplt_pkg::bits_t    sensor_bits;

	modport source (output valid, output sensor_bits, input ready);
	modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface lplt_out_if;
	logic               valid;
	logic               ready;
	lplt_pkg::pos_t     position_error;
	lplt_pkg::status_t  status;

	modport source (output valid, output position_error, output status, input ready);
	modport sink   (input valid, input position_error, input status, output ready);
endinterface

/* design/lplt_ctrl.sv */
// Controller: sequences load, divide steps and result write, owns handshakes.
// Depends on lplt_pkg.
module lplt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output lplt_pkg::lplt_cmd_t cmd
);
	import lplt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	logic [1:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = S_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/lplt_datapath.sv */
// Datapath: weighted sum, tracking state, threshold register, radix-4 divider,
// and the result register. Depends on lplt_pkg.
module lplt_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  lplt_pkg::lplt_cmd_t cmd,
	input  lplt_pkg::bits_t     sensor_bits,
	input  logic                cfg_we,
	input  lplt_pkg::count_t    cfg_data,
	output lplt_pkg::pos_t      position_error,
	output lplt_pkg::status_t   status
);
	import lplt_pkg::*;

	bits_t   last_pat_q;
	count_t  count_q;
	count_t  thr_q;

	logic signed [4:0] total;
	logic [3:0]        hits;
	logic [3:0]        mag_total;
	count_t            count_next;
	status_t           status_new;

	logic [11:0] dvd_q;
	logic [2:0]  rem_q;
	logic [3:0]  div_q;
	logic        neg_q;
	status_t     status_s1;

	logic [11:0] dvd_d;
	logic [2:0]  rem_d;
	pos_t        pos_q;
	status_t     status_q;

	always_comb begin
		total = '0;
		hits  = '0;
		for (int k = 0; k < 8; k++) begin
			if (sensor_bits[k]) begin
				total = total + 5'(sensor_weight(3'(k)));
				hits  = hits + 4'd1;
			end
		end
		mag_total = total[4] ? 4'(-total) : total[3:0];
	end

	always_comb begin
		count_next = (count_q == COUNT_MAX) ? count_q : count_q + 8'd1;
		if (last_pat_q == EDGE_LEFT_ONLY || last_pat_q == EDGE_RIGHT_ONLY) begin
			status_new = ST_EDGE;
		end else if (count_next >= thr_q) begin
			status_new = ST_NODE;
		end else begin
			status_new = ST_COAST;
		end
	end

	// two restoring steps per cycle; quotient bits shift in from the bottom
	always_comb begin
		logic [3:0] trial;
		dvd_d = dvd_q;
		rem_d = rem_q;
		for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
			trial = {rem_d, dvd_d[11]};
			if (trial >= div_q) begin
				rem_d = 3'(trial - div_q);
				dvd_d = {dvd_d[10:0], 1'b1};
			end else begin
				rem_d = trial[2:0];
				dvd_d = {dvd_d[10:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pat_q <= RESET_PATTERN;
			count_q    <= '0;
			thr_q      <= RESET_THRESHOLD;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
			if (cmd.load) begin
				if (hits != 4'd0) begin
					last_pat_q <= sensor_bits;
					count_q    <= '0;
				end else begin
					count_q <= count_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q     <= {mag_total, 8'd0};
			rem_q     <= '0;
			div_q     <= hits;
			neg_q     <= total[4];
			status_s1 <= (hits != 4'd0) ? ST_TRACK : status_new;
		end
		if (cmd.step) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
		end
		if (cmd.emit) begin
			status_q <= status_s1;
			if (status_s1 != ST_TRACK) begin
				pos_q <= '0;
			end else begin
				pos_q <= neg_q ? -$signed(dvd_q) : $signed(dvd_q);
			end
		end
	end

	assign position_error = pos_q;
	assign status         = status_q;

endmodule

/* design/line_position_lost_line_tracker.sv */
// channel   dir   handshake      payload
// sensor    in    valid/ready    sensor_bits[7:0]
// result    out   valid/ready    position_error[11:0] signed, status[1:0]
// cfg       in    cfg_we         cfg_data[7:0] -> lost_threshold
//
// Each word goes through accept, the 2-bit-per-cycle divider, then the write
// into the result register. A new word is taken only after the last one is written there.
// A finished word waits in the result register while the next one is taken.
// If the result register is still full at the end, the word holds in the
// divider until the sink takes it. Reset is asynchronous; no clearing pass.
// Top level; depends on lplt_pkg, lplt_if, lplt_ctrl, lplt_datapath, macros.
`include "line_position_lost_line_tracker_macros.svh"
module line_position_lost_line_tracker (
	input  logic               clk,
	input  logic               arst_n,
	lplt_in_if.sink            sensor,
	lplt_out_if.source         result,
	input  logic               cfg_we,
	input  lplt_pkg::count_t   cfg_data
);
	import lplt_pkg::*;

	lplt_cmd_t cmd;

	lplt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sensor.valid),
		.in_ready  (sensor.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	lplt_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sensor_bits    (sensor.sensor_bits),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.position_error (result.position_error),
		.status         (result.status)
	);

	// one word in flight: no new accept right after one
	`LPLT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, sensor.valid && sensor.ready, !sensor.ready)
	// lost-line words carry a zero position
	`LPLT_ASSERT_SAME(a_lost_zero_pos, clk, arst_n, result.valid && result.status != ST_TRACK, result.position_error == 12'sd0)
	// tracked position stays within the weight span
	`LPLT_ASSERT_SAME(a_pos_range, clk, arst_n, result.valid && result.status == ST_TRACK, result.position_error >= -12'sd1024 && result.position_error <= 12'sd1024)

endmodule
